[rtl/core/wsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Wind speed averager package
// Shared defaults, limits, polynomial coefficients, register indexes and the multiplier request type.
// ----------------------------------------------------------------------------
package wsa_pkg;

    localparam int unsigned SampleCountDefault = 16;

    localparam logic [1:0] RegAdcFullScale = 2'd0;
    localparam logic [1:0] RegVoltMin      = 2'd1;
    localparam logic [1:0] RegVoltMax      = 2'd2;
    localparam logic [1:0] RegSpeedMax     = 2'd3;

    localparam logic [63:0] CoefX4 = 64'd18447;
    localparam logic [63:0] CoefX3 = 64'd136241887;
    localparam logic [63:0] CoefX2 = 64'd347273435993;
    localparam logic [63:0] CoefX1 = 64'd1278612167474728;
    localparam logic [63:0] CoefX0 = 64'd39364803793714800;

    localparam logic [21:0] VoltMaxQ20  = 22'h3FFFFF;
    localparam logic [23:0] SpeedMaxQ16 = 24'hFFFFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] mul_a;
        logic [63:0] mul_b;
    } t_mul_req;

endpackage
`default_nettype wire

[rtl/core/wsa_serial_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Wind speed averager serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, low 64 bits kept.
// ----------------------------------------------------------------------------
module wsa_serial_mul (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire wsa_pkg::t_mul_req i_req,
    output logic                 o_done,
    output logic [63:0]          o_prod
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic        r_busy;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == 64'd0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.mul_a;
            r_b   <= i_req.mul_b;
            r_acc <= 64'd0;
        end else if (r_busy && (r_b != 64'd0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[62:0], 1'b0};
            r_b <= {1'b0, r_b[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

[rtl/core/wsa_serial_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Wind speed averager serial divider
// Restoring divider, one quotient bit per cycle, 64 quotient bits.
// ----------------------------------------------------------------------------
module wsa_serial_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic [63:0] r_q;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= 64'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= 64'(w_trial - {1'b0, r_den});
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_trial[63:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

[rtl/core/wind_speed_from_adc_averaged_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Wind speed averager top level
// ADC code to averaged wind speed in tenths of km/h.
// ----------------------------------------------------------------------------
// One sample is handled at a time. Seven bit-serial products build the
// polynomial, each stepping through one multiplier bit per cycle; the widest
// multiplier coefficient has 51 bits. One more product does the speed scaling.
// Up to three restoring divisions follow, for the speed, the old mean and the
// output. A code outside the valid range skips the products and the speed
// division. The result register holds a finished item while the next sample
// is taken in.
module wind_speed_from_adc_averaged_top #(
    parameter int unsigned SAMPLE_COUNT = wsa_pkg::SampleCountDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [11:0] i_adc_sample,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_speed_tenths_kmh,
    output logic             o_sample_valid,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    localparam int CntW = $clog2(SAMPLE_COUNT + 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL   = 13'b0000000000010,
        S_MWAIT = 13'b0000000000100,
        S_POLY  = 13'b0000000001000,
        S_SMUL  = 13'b0000000010000,
        S_SWAIT = 13'b0000000100000,
        S_SDIV  = 13'b0000001000000,
        S_SDWT  = 13'b0000010000000,
        S_ADIV  = 13'b0000100000000,
        S_ADWT  = 13'b0001000000000,
        S_ODIV  = 13'b0010000000000,
        S_ODWT  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    logic [11:0] r_fs, r_vmin, r_vmax;
    logic [9:0]  r_smax;
    logic [39:0] r_sum;
    logic [CntW-1:0] r_cnt;
    logic [11:0] r_x;
    logic        r_sv;
    logic [2:0]  r_step;
    logic [63:0] r_x2, r_x3, r_x4, r_pos, r_neg;
    logic [21:0] r_v;
    logic [63:0] r_num;
    logic [23:0] r_speed;
    logic [11:0] r_kmh;
    logic        r_ovalid;
    logic        r_osv;

    wsa_pkg::t_mul_req w_req;
    logic        w_mdone, w_ddone, w_dstart;
    logic [63:0] w_prod, w_quot, w_dnum, w_dden;
    logic [63:0] w_diff, w_vr;
    logic [63:0] w_scaled, w_vmin_q, w_num;
    logic [12:0] w_dv;
    logic [39:0] w_sub;

    assign w_dv = {1'b0, r_vmax} - {1'b0, r_vmin};

    assign w_scaled = {32'd0, r_v, 10'd0} - {38'd0, r_v, 4'd0} - {39'd0, r_v, 3'd0};
    assign w_vmin_q = {32'd0, r_vmin, 20'd0};
    assign w_num    = w_scaled - w_vmin_q;

    wsa_serial_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_mdone),
        .o_prod (w_prod)
    );

    wsa_serial_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    always_comb begin
        w_req.start = (r_state == S_MUL) || (r_state == S_SMUL);
        w_req.mul_a = 64'd0;
        w_req.mul_b = 64'd0;
        if (r_state == S_SMUL) begin
            w_req.mul_a = w_num;
            w_req.mul_b = {54'd0, r_smax};
        end else begin
            case (r_step)
                3'd0: begin w_req.mul_a = {52'd0, r_x}; w_req.mul_b = {52'd0, r_x}; end
                3'd1: begin w_req.mul_a = r_x2; w_req.mul_b = {52'd0, r_x}; end
                3'd2: begin w_req.mul_a = r_x2; w_req.mul_b = r_x2; end
                3'd3: begin w_req.mul_a = r_x3; w_req.mul_b = wsa_pkg::CoefX3; end
                3'd4: begin w_req.mul_a = {52'd0, r_x}; w_req.mul_b = wsa_pkg::CoefX1; end
                3'd5: begin w_req.mul_a = r_x4; w_req.mul_b = wsa_pkg::CoefX4; end
                3'd6: begin w_req.mul_a = r_x2; w_req.mul_b = wsa_pkg::CoefX2; end
                default: begin w_req.mul_a = 64'd0; w_req.mul_b = 64'd0; end
            endcase
        end
    end

    always_comb begin
        w_dstart = (r_state == S_SDIV) || (r_state == S_ADIV) || (r_state == S_ODIV);
        w_dnum = 64'd0;
        w_dden = 64'd1;
        case (r_state)
            S_SDIV: begin
                w_dnum = r_num + 64'(80 * {51'd0, w_dv});
                w_dden = 64'(160 * {51'd0, w_dv});
            end
            S_ADIV: begin
                w_dnum = {24'd0, r_sum};
                w_dden = {{(64-CntW){1'b0}}, r_cnt};
            end
            S_ODIV: begin
                w_dnum = ({19'd0, r_sum, 5'd0} + {22'd0, r_sum, 2'd0})
                    + ({{(64-CntW){1'b0}}, r_cnt} << 15);
                w_dden = {{(64-CntW){1'b0}}, r_cnt} << 16;
            end
            default: begin
                w_dnum = 64'd0;
                w_dden = 64'd1;
            end
        endcase
    end

    assign w_diff = r_pos - r_neg;
    assign w_vr   = w_diff + (64'd1 << 39);
    assign w_sub  = (r_sum >= w_quot[39:0]) ? (r_sum - w_quot[39:0]) : 40'd0;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fs     <= 12'd4095;
            r_vmin   <= 12'd400;
            r_vmax   <= 12'd2000;
            r_smax   <= 10'd324;
            r_sum    <= 40'd0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_step   <= 3'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wsa_pkg::RegAdcFullScale: r_fs   <= i_cfg_data;
                    wsa_pkg::RegVoltMin:      r_vmin <= i_cfg_data;
                    wsa_pkg::RegVoltMax:      r_vmax <= i_cfg_data;
                    wsa_pkg::RegSpeedMax:     r_smax <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_x     <= i_adc_sample;
                        r_sv    <= (i_adc_sample != 12'd0) && (i_adc_sample <= r_fs);
                        r_speed <= 24'd0;
                        r_step  <= 3'd0;
                        r_pos   <= wsa_pkg::CoefX0;
                        r_neg   <= 64'd0;
                        if ((i_adc_sample != 12'd0) && (i_adc_sample <= r_fs)) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_ADIV;
                        end
                    end
                end
                S_MUL: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (w_mdone) begin
                        case (r_step)
                            3'd0: r_x2 <= w_prod;
                            3'd1: r_x3 <= w_prod;
                            3'd2: r_x4 <= w_prod;
                            3'd3: r_pos <= r_pos + w_prod;
                            3'd4: r_pos <= r_pos + w_prod;
                            3'd5: r_neg <= r_neg + w_prod;
                            3'd6: r_neg <= r_neg + w_prod;
                            default: ;
                        endcase
                        r_step  <= r_step + 3'd1;
                        r_state <= (r_step == 3'd6) ? S_POLY : S_MUL;
                    end
                end
                S_POLY: begin
                    if (r_pos <= r_neg) begin
                        r_v <= 22'd0;
                    end else if (w_vr[63:40] > {2'd0, wsa_pkg::VoltMaxQ20}) begin
                        r_v <= wsa_pkg::VoltMaxQ20;
                    end else begin
                        r_v <= w_vr[61:40];
                    end
                    r_state <= S_SMUL;
                    r_num   <= 64'd0;
                end
                S_SMUL: begin
                    if ((r_vmax <= r_vmin) || (w_scaled <= w_vmin_q)) begin
                        r_state <= S_ADIV;
                    end else begin
                        r_state <= S_SWAIT;
                    end
                end
                S_SWAIT: if (w_mdone) begin
                    r_num   <= w_prod;
                    r_state <= S_SDIV;
                end
                S_SDIV: r_state <= S_SDWT;
                S_SDWT: if (w_ddone) begin
                    r_speed <= (w_quot > {40'd0, wsa_pkg::SpeedMaxQ16})
                        ? wsa_pkg::SpeedMaxQ16 : w_quot[23:0];
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    if (r_cnt == '0) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_sum   <= r_sum + {16'd0, r_speed};
                        r_state <= S_ODIV;
                    end else begin
                        r_state <= S_ADWT;
                    end
                end
                S_ADWT: if (w_ddone) begin
                    if (r_cnt < CntW'(SAMPLE_COUNT)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_sum <= r_sum + {16'd0, r_speed};
                    end else begin
                        r_sum <= w_sub + {16'd0, r_speed};
                    end
                    r_state <= S_ODIV;
                end
                S_ODIV: r_state <= S_ODWT;
                S_ODWT: if (w_ddone) begin
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_kmh    <= (w_quot > 64'd4095) ? 12'd4095 : w_quot[11:0];
                    r_osv    <= r_sv;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: ;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_speed_tenths_kmh = r_kmh;
    assign o_sample_valid     = r_osv;

endmodule
`default_nettype wire

[rtl/core/wsa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Wind speed averager port checker
// Watches the top-level ports and flags handshake and ordering slips.
// ----------------------------------------------------------------------------
module wsa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [11:0] i_speed,
    input wire logic        i_sample_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_speed)
            && $stable(i_sample_valid))
        else $error("Result changed while stalled.");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Second item taken while one is in work.");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("Result appeared too early.");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_speed, i_sample_valid}))
        else $error("Result item carries unknown bits.");

endmodule

bind wind_speed_from_adc_averaged_top wsa_checker u_wsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_valid),
    .i_in_ready    (o_ready),
    .i_out_valid   (o_valid),
    .i_out_ready   (i_ready),
    .i_speed       (o_speed_tenths_kmh),
    .i_sample_valid(o_sample_valid)
);
`default_nettype wire
